@@ sv/stbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg: shared types and constants
// Item kinds, engine states and fixed field widths of the sorted-table search.
// ----------------------------------------------------------------------------
package stbs_pkg;

	// fixed widths of the channel and register fields
	localparam int COUNT_W = 11;
	localparam int INDEX_W = 10;
	localparam int KEY_W   = 32;

	// depth of the queue between front and engine
	localparam int QUEUE_DEPTH = 2;

	// opcode values of a request beat
	localparam logic OPC_WRITE  = 1'b0;
	localparam logic OPC_SEARCH = 1'b1;

	// what the front hands to the engine
	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_SEARCH,
		KIND_EMPTY
	} kind_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_PROBE,
		ENG_CMP,
		ENG_RESULT
	} eng_state_t;

endpackage

@@ sv/stbs_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_req_if: request channel
// Valid/ready channel carrying table writes and search keys.
// ----------------------------------------------------------------------------
interface stbs_req_if;
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic [stbs_pkg::INDEX_W-1:0]  entry_index;
	logic [stbs_pkg::KEY_W-1:0]    data_word;

	modport source (output valid, output opcode, output entry_index, output data_word,
		input ready);
	modport sink (input valid, input opcode, input entry_index, input data_word,
		output ready);
endinterface

@@ sv/stbs_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_rsp_if: result channel
// Valid/ready channel carrying one search result per beat.
// ----------------------------------------------------------------------------
interface stbs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [stbs_pkg::INDEX_W-1:0]  match_index;

	modport source (output valid, output found, output match_index, input ready);
	modport sink (input valid, input found, input match_index, output ready);
endinterface

@@ sv/stbs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/stbs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_front: request intake
// Holds the entry count, takes request beats and turns them into queue words.
// ----------------------------------------------------------------------------
module stbs_front #(
	parameter int TABLE_DEPTH = 1024,
	parameter int ENTRY_WIDTH = 32,
	parameter int QW          = 2 + 2 * $clog2(TABLE_DEPTH) + ENTRY_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [stbs_pkg::COUNT_W-1:0] cfg_wdata,
	stbs_req_if.sink                     req,
	input  logic                         q_full,
	output logic                         q_push,
	output logic [QW-1:0]                q_din
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int KW = (CW > stbs_pkg::COUNT_W) ? CW : stbs_pkg::COUNT_W;

	logic [stbs_pkg::COUNT_W-1:0] entry_count_q;
	logic [KW-1:0]                count_ext;
	logic [CW-1:0]                count_sat;
	logic                         in_range;
	stbs_pkg::kind_t              kind;
	logic [AW-1:0]                addr;
	logic [AW-1:0]                hi;
	logic [ENTRY_WIDTH-1:0]       word;
	logic                         beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	// counts above the table size saturate
	always_comb begin
		count_ext = KW'(entry_count_q);
		if (count_ext > KW'(TABLE_DEPTH)) begin
			count_sat = CW'(TABLE_DEPTH);
		end else begin
			count_sat = CW'(count_ext);
		end
	end

	assign in_range = 32'(req.entry_index) < 32'(TABLE_DEPTH);
	assign word     = ENTRY_WIDTH'(req.data_word);
	assign hi       = AW'(count_sat - CW'(1));
	assign beat     = req.valid && req.ready;

	always_comb begin
		kind   = stbs_pkg::KIND_WRITE;
		addr   = '0;
		q_push = 1'b0;
		case (req.opcode)
			stbs_pkg::OPC_WRITE: begin
				kind   = stbs_pkg::KIND_WRITE;
				addr   = AW'(req.entry_index);
				// writes past the table are dropped here
				q_push = beat && in_range;
			end
			default: begin
				kind   = (count_sat == '0) ? stbs_pkg::KIND_EMPTY : stbs_pkg::KIND_SEARCH;
				q_push = beat;
			end
		endcase
	end

	assign q_din     = {kind, addr, word, hi};
	assign req.ready = !q_full;

endmodule

@@ sv/stbs_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_queue: small first-word-fall-through queue
// Decouples request intake from the search engine.
// ----------------------------------------------------------------------------
module stbs_queue #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [FW-1:0]    fill_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	assign dout  = mem_q[rd_ptr_q];
	assign full  = (fill_q == FW'(DEPTH));
	assign empty = (fill_q == '0);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue pop while empty");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("queue fill count past depth");
`endif

endmodule

@@ sv/stbs_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_engine: table writer and binary search sequencer
// Pops queue words, writes the table and runs probe/compare steps.
// ----------------------------------------------------------------------------
module stbs_engine #(
	parameter int TABLE_DEPTH = 1024,
	parameter int ENTRY_WIDTH = 32,
	parameter int QW          = 2 + 2 * $clog2(TABLE_DEPTH) + ENTRY_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  logic [QW-1:0]                  q_dout,
	output logic                           q_pop,
	output logic                           ram_we,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
	output logic [ENTRY_WIDTH-1:0]         ram_wdata,
	output logic                           ram_re,
	output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
	input  logic [ENTRY_WIDTH-1:0]         ram_rdata,
	stbs_rsp_if.source                     rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int KW = $bits(stbs_pkg::kind_t);

	stbs_pkg::eng_state_t state_q, state_d;

	stbs_pkg::kind_t              q_kind;
	logic [AW-1:0]                q_addr;
	logic [ENTRY_WIDTH-1:0]       q_word;
	logic [AW-1:0]                q_hi;

	logic [CW-1:0]                lo_q;
	logic [AW-1:0]                hi_q;
	logic [AW-1:0]                mid_q;
	logic [ENTRY_WIDTH-1:0]       key_q;
	logic                         hit_q;

	logic [AW-1:0]                mid_c;
	logic [CW-1:0]                mid_plus;
	logic                         eq_c;
	logic                         lt_c;
	logic                         done_c;
	logic                         slot_free;
	logic                         out_load;

	logic                         out_valid_q;
	logic                         found_q;
	logic [stbs_pkg::INDEX_W-1:0] idx_q;

	assign q_kind = stbs_pkg::kind_t'(q_dout[QW-1 -: KW]);
	assign q_addr = q_dout[QW-KW-1 -: AW];
	assign q_word = q_dout[AW+ENTRY_WIDTH-1 -: ENTRY_WIDTH];
	assign q_hi   = q_dout[AW-1:0];

	// midpoint of the live range, lo never passes hi while probing
	assign mid_c    = AW'(lo_q) + ((hi_q - AW'(lo_q)) >> 1);
	assign mid_plus = CW'(mid_q) + CW'(1);
	assign eq_c     = (ram_rdata == key_q);
	assign lt_c     = (ram_rdata < key_q);

	always_comb begin
		if (eq_c) begin
			done_c = 1'b1;
		end else if (lt_c) begin
			done_c = (mid_plus > CW'(hi_q));
		end else begin
			done_c = (mid_q == '0) || (CW'(mid_q) == lo_q);
		end
	end

	assign slot_free = !out_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stbs_pkg::ENG_IDLE: begin
				if (!q_empty) begin
					unique case (q_kind)
						stbs_pkg::KIND_SEARCH: state_d = stbs_pkg::ENG_PROBE;
						stbs_pkg::KIND_EMPTY:  state_d = stbs_pkg::ENG_RESULT;
						default:               state_d = stbs_pkg::ENG_IDLE;
					endcase
				end
			end
			stbs_pkg::ENG_PROBE: state_d = stbs_pkg::ENG_CMP;
			stbs_pkg::ENG_CMP: begin
				state_d = done_c ? stbs_pkg::ENG_RESULT : stbs_pkg::ENG_PROBE;
			end
			stbs_pkg::ENG_RESULT: begin
				if (slot_free) begin
					state_d = stbs_pkg::ENG_IDLE;
				end
			end
			default: state_d = stbs_pkg::ENG_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop    = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			stbs_pkg::ENG_IDLE: begin
				q_pop  = !q_empty;
				ram_we = !q_empty && (q_kind == stbs_pkg::KIND_WRITE);
			end
			stbs_pkg::ENG_PROBE:  ram_re   = 1'b1;
			stbs_pkg::ENG_RESULT: out_load = slot_free;
			default: ;
		endcase
	end

	assign ram_waddr = q_addr;
	assign ram_wdata = q_word;
	assign ram_raddr = mid_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stbs_pkg::ENG_IDLE;
			lo_q        <= '0;
			hi_q        <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && (q_kind != stbs_pkg::KIND_WRITE)) begin
				hit_q <= 1'b0;
				if (q_kind == stbs_pkg::KIND_SEARCH) begin
					lo_q <= '0;
					hi_q <= q_hi;
				end
			end
			if (state_q == stbs_pkg::ENG_CMP) begin
				if (eq_c) begin
					hit_q <= 1'b1;
				end else if (lt_c) begin
					lo_q <= mid_plus;
				end else if (mid_q != '0) begin
					hi_q <= mid_q - AW'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && (q_kind == stbs_pkg::KIND_SEARCH)) begin
			key_q <= q_word;
		end
		if (state_q == stbs_pkg::ENG_PROBE) begin
			mid_q <= mid_c;
		end
		if (out_load) begin
			found_q <= hit_q;
			idx_q   <= hit_q ? stbs_pkg::INDEX_W'(mid_q) : '0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = found_q;
	assign rsp.match_index = idx_q;

`ifndef SYNTHESIS
	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (AW'(lo_q) <= mid_c) && (mid_c <= hi_q) && (lo_q <= CW'(hi_q)))
		else $error("probe outside live range");
	a_cmp_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == stbs_pkg::ENG_CMP |-> (lo_q <= CW'(mid_q)) && (mid_q <= hi_q))
		else $error("compare step with midpoint outside range");
	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> idx_q == '0)
		else $error("miss carries a nonzero index");
	a_load_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("result lost at output register");
`endif

endmodule

@@ sv/sorted_table_binary_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search: table store with binary search
// Write beats fill an ascending table, search beats return found flag and index.
// ----------------------------------------------------------------------------
//
// channel   dir   handshake          payload
// req       in    req.valid/ready    opcode, entry_index, data_word
// rsp       out   rsp.valid/ready    found, match_index
// cfg       in    cfg_we             cfg_wdata = entry_count
//
// a write beat is written to the table in the idle state; a search runs p probes,
// at most floor(log2(count)) + 1 (11 for 1024 entries); each probe is one
// registered table read followed by one compare, so the single RAM read port
// sets the search time
// requests queue in a two-deep buffer: intake takes up to two beats while a
// search runs, then stalls until the engine pops
// a finished result sits in the output register while the next item is taken
// no clearing pass after reset: table entries are valid only once written
//
module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = 1024,
	parameter int ENTRY_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	stbs_req_if.sink                     req,
	stbs_rsp_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic [stbs_pkg::COUNT_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(TABLE_DEPTH);
	// queue word: kind, write address, word or key, initial high bound
	localparam int QW = $bits(stbs_pkg::kind_t) + 2 * AW + ENTRY_WIDTH;

	logic                   q_push;
	logic                   q_pop;
	logic                   q_full;
	logic                   q_empty;
	logic [QW-1:0]          q_din;
	logic [QW-1:0]          q_dout;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [ENTRY_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [ENTRY_WIDTH-1:0] ram_rdata;

	// intake: count register, write range check, empty-table detection
	stbs_front #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH),
		.QW          (QW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_din     (q_din)
	);

	// decoupling buffer, keeps writes and searches in arrival order
	stbs_queue #(
		.WIDTH (QW),
		.DEPTH (stbs_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	// table storage
	stbs_ram #(
		.WIDTH (ENTRY_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// writes and probe/compare sequencing, result register
	stbs_engine #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH),
		.QW          (QW)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_dout    (q_dout),
		.q_pop     (q_pop),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.rsp       (rsp)
	);

endmodule

@@ dv/tb_sorted_table_binary_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search: self-checking bench for the table search
// Fills the table through write beats, sets the entry count between phases and
// checks every search result against a bit-accurate binary search over a local
// copy of the table. Both channels idle at random, and once the result side
// holds off long enough for the request side to back up.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search;

	// table size of the instance under test
	localparam int DEPTH = 1024;
	// extra cycles after the last result before the block counts as idle
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_ITEMS = 1650;
	localparam int CYCLE_LIMIT = 400000;
	// long result-side hold-off, long enough to fill the request queue
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct packed {
		logic                         found;
		logic [stbs_pkg::INDEX_W-1:0] match_index;
	} search_result_t;

	// local copy of the table and entry count, queue of awaited search results
	class search_result_tracker;
		logic [stbs_pkg::KEY_W-1:0] entry_words [DEPTH];
		int unsigned                active_count;
		search_result_t             awaited_results [$];
		int unsigned                mismatches;

		function new();
			foreach (entry_words[i])
				entry_words[i] = '0;
			active_count = 0;
			mismatches = 0;
		endfunction

		// binary search with the block's probe rules
		function search_result_t lookup(input logic [stbs_pkg::KEY_W-1:0] key);
			search_result_t res;
			int lo;
			int hi;
			int mid;
			int span;
			res = '0;
			span = (active_count > DEPTH) ? DEPTH : int'(active_count);
			if (span == 0)
				return res;
			lo = 0;
			hi = span - 1;
			while (lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (entry_words[mid] == key) begin
					res.found = 1'b1;
					res.match_index = mid[stbs_pkg::INDEX_W-1:0];
					return res;
				end else if (entry_words[mid] < key) begin
					lo = mid + 1;
				end else begin
					// probe at index 0 already above the key
					if (mid == 0)
						return res;
					hi = mid - 1;
				end
			end
			return res;
		endfunction

		function void note_request(input logic op,
			input logic [stbs_pkg::INDEX_W-1:0] idx,
			input logic [stbs_pkg::KEY_W-1:0] word);
			if (op == stbs_pkg::OPC_WRITE)
				entry_words[idx] = word;
			else
				awaited_results.push_back(lookup(word));
		endfunction

		function void check_result(input logic found,
			input logic [stbs_pkg::INDEX_W-1:0] idx);
			search_result_t exp;
			if (awaited_results.size() == 0) begin
				$display("%0t: result with nothing awaited: found=%0b match_index=%0d",
					$time, found, idx);
				mismatches++;
				return;
			end
			exp = awaited_results.pop_front();
			if (found !== exp.found) begin
				$display("%0t: found expected %0b actual %0b", $time, exp.found, found);
				mismatches++;
			end
			if (idx !== exp.match_index) begin
				$display("%0t: match_index expected %0d actual %0d", $time,
					exp.match_index, idx);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [stbs_pkg::COUNT_W-1:0] cfg_wdata;

	stbs_req_if req_ch();
	stbs_rsp_if rsp_ch();

	sorted_table_binary_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	search_result_tracker tracker;

	// idle odds in percent, changed as the run goes on
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	// set by the stimulus side, taken over by the result side
	int unsigned hold_request;
	int unsigned items_sent;
	int unsigned cycle_count;

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: a hung handshake or a lost result ends here
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// result side: check every accepted beat, then pick ready for the next edge
	initial begin : result_sink
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				tracker.check_result(rsp_ch.found, rsp_ch.match_index);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				// long hold-off, counted here, while requests keep coming
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// offer one request beat and wait for it to be taken
	task automatic send_item(input logic op, input logic [stbs_pkg::INDEX_W-1:0] idx,
		input logic [stbs_pkg::KEY_W-1:0] word);
		// idle profile: receiver-heavy, then sender-heavy, then no idling at all
		if (items_sent < 500) begin
			tx_idle_pct = 27;
			rx_idle_pct = 47;
		end else if (items_sent < 1100) begin
			tx_idle_pct = 47;
			rx_idle_pct = 27;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		// each cycle the sender idles with the current odds
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.entry_index <= idx;
		req_ch.data_word <= word;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		tracker.note_request(op, idx, word);
		items_sent++;
	endtask

	// stop offering, let all awaited results arrive and the engine drain
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (tracker.awaited_results.size() != 0)
			@(posedge clk);
		// a trailing write beat gives no result but may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// entry count changes only while the block is idle
	task automatic set_entry_count(input int n);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= n[stbs_pkg::COUNT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.active_count = n[stbs_pkg::COUNT_W-1:0];
	endtask

	// ascending values in entries 0..n-1, none above ceiling, some repeats
	task automatic fill_ascending(input int n, input logic [stbs_pkg::KEY_W-1:0] ceiling);
		logic [stbs_pkg::KEY_W-1:0] step_max;
		logic [stbs_pkg::KEY_W-1:0] value;
		step_max = ceiling / n;
		value = '0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(7) != 0)
				value += $urandom_range(step_max, 0);
			send_item(stbs_pkg::OPC_WRITE, i[stbs_pkg::INDEX_W-1:0], value);
		end
	endtask

	// key near a stored entry most of the time, else an extreme or random word
	function automatic logic [stbs_pkg::KEY_W-1:0] pick_key(input int n);
		logic [stbs_pkg::KEY_W-1:0] base;
		base = (n > 0) ? tracker.entry_words[$urandom_range(n - 1, 0)] : $urandom();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return $urandom();
			4: return base + 1'b1;
			5: return base - 1'b1;
			default: return base;
		endcase
	endfunction

	// one phase: new count, table update that keeps the probed range written,
	// then a burst of searches
	task automatic run_random_phase();
		int n;
		int span;
		int idx;
		case ($urandom_range(9))
			0: n = 0;
			1: n = 1;
			2: n = 2;
			3, 4, 5: n = $urandom_range(48, 3);
			6: n = DEPTH;
			7: n = $urandom_range(2047, DEPTH + 1);
			8: n = 2047;
			default: n = $urandom_range(DEPTH - 1, 500);
		endcase
		set_entry_count(n);
		span = (n > DEPTH) ? DEPTH : n;
		if (span != 0 && span <= 48) begin
			if ($urandom_range(7) == 0) begin
				// unsorted prefix: the search just follows its probe rules
				for (int i = 0; i < span; i++)
					send_item(stbs_pkg::OPC_WRITE, i[stbs_pkg::INDEX_W-1:0], $urandom());
			end else begin
				// stay below the next entry so the whole table stays ascending
				fill_ascending(span, tracker.entry_words[span]);
			end
		end else if (span > 48) begin
			// a few overwrites that sit between their neighbors
			repeat ($urandom_range(4)) begin
				idx = $urandom_range(DEPTH - 2, 1);
				send_item(stbs_pkg::OPC_WRITE, idx[stbs_pkg::INDEX_W-1:0],
					$urandom_range(tracker.entry_words[idx + 1],
					tracker.entry_words[idx - 1]));
			end
		end
		// entry_index of a search is ignored, so it carries noise
		repeat ($urandom_range(24, 8))
			send_item(stbs_pkg::OPC_SEARCH, stbs_pkg::INDEX_W'($urandom()), pick_key(span));
	endtask

	initial begin : stimulus
		int unsigned directed_items;
		tracker = new();
		items_sent = 0;
		hold_request = 0;
		tx_idle_pct = 27;
		rx_idle_pct = 47;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = stbs_pkg::OPC_WRITE;
		req_ch.entry_index = '0;
		req_ch.data_word = '0;
		rsp_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty table: nothing is probed, nothing found
		set_entry_count(0);
		send_item(stbs_pkg::OPC_SEARCH, '0, '0);
		send_item(stbs_pkg::OPC_SEARCH, '1, '1);

		// small ascending table with the word extremes, plus the top index
		send_item(stbs_pkg::OPC_WRITE, 10'd0, 32'h0000_0000);
		send_item(stbs_pkg::OPC_WRITE, 10'd1, 32'h0000_0005);
		send_item(stbs_pkg::OPC_WRITE, 10'd2, 32'h0000_0009);
		send_item(stbs_pkg::OPC_WRITE, 10'd3, 32'hFFFF_FFFF);
		send_item(stbs_pkg::OPC_WRITE, 10'd1023, 32'hFFFF_FFFF);
		set_entry_count(4);
		send_item(stbs_pkg::OPC_SEARCH, '0, 32'h0000_0000);
		send_item(stbs_pkg::OPC_SEARCH, '0, 32'h0000_0005);
		send_item(stbs_pkg::OPC_SEARCH, '1, 32'h0000_0009);
		send_item(stbs_pkg::OPC_SEARCH, '0, 32'hFFFF_FFFF);
		// absent keys between entries and just past one
		send_item(stbs_pkg::OPC_SEARCH, '0, 32'h0000_0003);
		send_item(stbs_pkg::OPC_SEARCH, '0, 32'h0000_000A);
		send_item(stbs_pkg::OPC_SEARCH, '0, 32'h0000_0007);

		// single entry: hit, and a miss that walks right off the end
		set_entry_count(1);
		send_item(stbs_pkg::OPC_SEARCH, '0, 32'h0000_0000);
		send_item(stbs_pkg::OPC_SEARCH, '0, 32'h0000_0001);
		// key below entry 0: search stops at index 0
		send_item(stbs_pkg::OPC_WRITE, 10'd0, 32'h0000_0005);
		send_item(stbs_pkg::OPC_SEARCH, '0, 32'h0000_0002);
		send_item(stbs_pkg::OPC_SEARCH, '0, 32'h0000_0005);
		// repeated value: the first midpoint that matches wins
		set_entry_count(4);
		send_item(stbs_pkg::OPC_SEARCH, '0, 32'h0000_0005);
		directed_items = items_sent;

		// full ascending table, every index written once
		set_entry_count(DEPTH);
		fill_ascending(DEPTH, '1);
		// result side holds off while searches pile up in the block
		hold_request = HOLD_OFF_CYCLES;
		repeat (150)
			send_item(stbs_pkg::OPC_SEARCH, stbs_pkg::INDEX_W'($urandom()), pick_key(DEPTH));

		while (items_sent - directed_items < RANDOM_ITEMS)
			run_random_phase();

		wait_idle();
		if (tracker.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ sorted_table_binary_search.f @@
sv/stbs_pkg.sv
sv/stbs_req_if.sv
sv/stbs_rsp_if.sv
sv/stbs_ram.sv
sv/stbs_front.sv
sv/stbs_queue.sv
sv/stbs_engine.sv
sv/sorted_table_binary_search.sv
dv/tb_sorted_table_binary_search.sv
